[design/thp_pkg.sv]
// ----------------------------------------------------------------------------
// thp_pkg: shared types and constants of the teredo header parser
// Transfer structs, parse phases, status codes and fixed widths.
// ----------------------------------------------------------------------------
`default_nettype none

package thp_pkg;

  localparam int LEN_WIDTH_DEF = 16;
  localparam int CNT_W         = 16;
  localparam int OFF_W         = 10;

  typedef enum logic [2:0] {
    PH_TAG0    = 3'd0,
    PH_TAG1    = 3'd1,
    PH_AUTH_ID = 3'd2,
    PH_AUTH_AU = 3'd3,
    PH_SKIP    = 3'd4,
    PH_IPV6    = 3'd5,
    PH_ERR     = 3'd6
  } phase_t;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_TRUNC_TAG    = 3'd1;
  localparam logic [2:0] ST_TRUNC_ORIGIN = 3'd2;
  localparam logic [2:0] ST_TRUNC_AUTH   = 3'd3;
  localparam logic [2:0] ST_SHORT_IPV6   = 3'd4;
  localparam logic [2:0] ST_LEN_MISMATCH = 3'd5;
  localparam logic [2:0] ST_MISORDERED   = 3'd6;
  localparam logic [2:0] ST_UNKNOWN_TAG  = 3'd7;

  localparam logic [7:0]       TAG_ORIGIN   = 8'd0;
  localparam logic [7:0]       TAG_AUTH     = 8'd1;
  localparam logic [3:0]       TAG_IPV6_NIB = 4'd6;
  localparam logic [OFF_W-1:0] ORIGIN_SKIP  = 10'd6;
  localparam logic [OFF_W-1:0] AUTH_SKIP    = 10'd9;
  localparam logic [CNT_W-1:0] IPV6_MIN     = 16'd40;
  localparam logic [CNT_W-1:0] IPV6_START   = 16'd2;
  localparam logic [CNT_W-1:0] PLEN_HI_POS  = 16'd4;
  localparam logic [CNT_W-1:0] PLEN_LO_POS  = 16'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic             packet_ok;
    logic [2:0]       status;
    logic [OFF_W-1:0] ipv6_offset;
    logic             origin_seen;
    logic [OFF_W-1:0] origin_offset;
    logic             auth_seen;
  } result_t;

endpackage

`default_nettype wire

[design/teredo_header_parser.sv]
// ----------------------------------------------------------------------------
// teredo_header_parser: teredo encapsulation header walker
// Walks origin and auth headers byte by byte, checks the inner ipv6 header
// and reports one result per packet on its last byte.
// ----------------------------------------------------------------------------
//  channel   direction  payload    transfer
//  item      in         item_t     item_valid & item_ready, one byte
//  result    out        result_t   result_valid & result_ready, per packet
//
//  one byte is taken every cycle while item_ready is high; the parse state updates in that cycle
//  the result is registered and shows in the cycle after the last byte is taken
//  item_ready drops only while a result waits and result_ready is low
//  rst is synchronous and returns the parser to the first tag byte
//  state returns to reset after every last byte
// ----------------------------------------------------------------------------
`default_nettype none

module teredo_header_parser
  import thp_pkg::*;
#(
  parameter int LEN_WIDTH = LEN_WIDTH_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output logic         item_ready,
  input  wire item_t   item,
  output logic         result_valid,
  input  wire logic    result_ready,
  output result_t      result
);

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'((32'd1 << LEN_WIDTH) - 32'd1);

  phase_t             phase, phase_next;
  logic [CNT_W-1:0]   byte_count, byte_count_next;
  logic [OFF_W-1:0]   header_start, header_start_next;
  logic [OFF_W-1:0]   skip_remaining, skip_remaining_next;
  logic [7:0]         tag_high, tag_high_next;
  logic [7:0]         id_length, id_length_next;
  logic [1:0]         seen_flags, seen_flags_next;
  logic [CNT_W-1:0]   payload_length, payload_length_next;
  logic [2:0]         error_code, error_code_next;
  logic [OFF_W-1:0]   origin_start, origin_start_next;
  logic [OFF_W-1:0]   skip_dec;
  result_t            result_next;
  logic               accept;

  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;
  assign skip_dec   = (skip_remaining != '0) ? skip_remaining - 1'b1 : skip_remaining;

  // next state
  always_comb begin
    phase_next          = phase;
    byte_count_next     = byte_count;
    header_start_next   = header_start;
    skip_remaining_next = skip_remaining;
    tag_high_next       = tag_high;
    id_length_next      = id_length;
    seen_flags_next     = seen_flags;
    payload_length_next = payload_length;
    error_code_next     = error_code;
    origin_start_next   = origin_start;
    case (phase)
      PH_TAG0: begin
        header_start_next = byte_count[OFF_W-1:0];
        tag_high_next     = item.data_byte;
        byte_count_next   = byte_count + 1'b1;
        phase_next        = PH_TAG1;
      end
      PH_TAG1: begin
        byte_count_next = byte_count + 1'b1;
        if (tag_high == 8'd0 && item.data_byte == TAG_ORIGIN) begin
          if (seen_flags[0]) begin
            error_code_next = ST_MISORDERED;
            phase_next      = PH_ERR;
          end else begin
            skip_remaining_next = ORIGIN_SKIP;
            error_code_next     = ST_TRUNC_ORIGIN;
            phase_next          = PH_SKIP;
          end
        end else if (tag_high == 8'd0 && item.data_byte == TAG_AUTH) begin
          if (seen_flags != 2'b00) begin
            error_code_next = ST_MISORDERED;
            phase_next      = PH_ERR;
          end else begin
            error_code_next = ST_TRUNC_AUTH;
            phase_next      = PH_AUTH_ID;
          end
        end else if (tag_high[7:4] == TAG_IPV6_NIB) begin
          byte_count_next     = IPV6_START;
          payload_length_next = '0;
          phase_next          = PH_IPV6;
        end else begin
          error_code_next = ST_UNKNOWN_TAG;
          phase_next      = PH_ERR;
        end
      end
      PH_AUTH_ID: begin
        id_length_next  = item.data_byte;
        byte_count_next = byte_count + 1'b1;
        phase_next      = PH_AUTH_AU;
      end
      PH_AUTH_AU: begin
        skip_remaining_next = AUTH_SKIP + OFF_W'(id_length) + OFF_W'(item.data_byte);
        byte_count_next     = byte_count + 1'b1;
        phase_next          = PH_SKIP;
      end
      PH_SKIP: begin
        byte_count_next     = byte_count + 1'b1;
        skip_remaining_next = skip_dec;
        if (skip_dec == '0) begin
          if (error_code == ST_TRUNC_ORIGIN) begin
            seen_flags_next[0] = 1'b1;
            origin_start_next  = header_start;
          end else begin
            seen_flags_next[1] = 1'b1;
          end
          phase_next = PH_TAG0;
        end
      end
      PH_IPV6: begin
        if (byte_count == PLEN_HI_POS) begin
          payload_length_next = {item.data_byte, payload_length[7:0]};
        end else if (byte_count == PLEN_LO_POS) begin
          payload_length_next = {payload_length[15:8], item.data_byte};
        end
        if (byte_count < CNT_MAX) begin
          byte_count_next = byte_count + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // result of a packet ending on this byte
  always_comb begin
    result_next               = '0;
    result_next.origin_seen   = seen_flags_next[0];
    result_next.origin_offset = seen_flags_next[0] ? origin_start_next : '0;
    result_next.auth_seen     = seen_flags_next[1];
    case (phase_next)
      PH_TAG0, PH_TAG1: begin
        result_next.status = ST_TRUNC_TAG;
      end
      PH_IPV6: begin
        if (byte_count_next < IPV6_MIN) begin
          result_next.status = ST_SHORT_IPV6;
        end else if (byte_count_next >= CNT_MAX ||
                     byte_count_next - IPV6_MIN != payload_length_next) begin
          result_next.status = ST_LEN_MISMATCH;
        end else begin
          result_next.status      = ST_OK;
          result_next.packet_ok   = 1'b1;
          result_next.ipv6_offset = header_start_next;
        end
      end
      default: begin
        result_next.status = error_code_next;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && item.last_byte)) begin
      phase          <= PH_TAG0;
      byte_count     <= '0;
      header_start   <= '0;
      skip_remaining <= '0;
      tag_high       <= '0;
      id_length      <= '0;
      seen_flags     <= '0;
      payload_length <= '0;
      error_code     <= ST_OK;
      origin_start   <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      byte_count     <= byte_count_next;
      header_start   <= header_start_next;
      skip_remaining <= skip_remaining_next;
      tag_high       <= tag_high_next;
      id_length      <= id_length_next;
      seen_flags     <= seen_flags_next;
      payload_length <= payload_length_next;
      error_code     <= error_code_next;
      origin_start   <= origin_start_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && item.last_byte) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && item.last_byte) begin
      result <= result_next;
    end
  end

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept && item.last_byte |=> result_valid)
    else $error("no result after last byte");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    !result_valid && !(accept && item.last_byte) |=> !result_valid)
    else $error("result without last byte");

  a_ok_status: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.packet_ok |-> result.status == ST_OK)
    else $error("packet_ok with error status");

  a_origin_offset: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.origin_seen |-> result.origin_offset == '0)
    else $error("origin offset without origin header");

  a_packet_restart: assert property (@(posedge clk) disable iff (rst)
    accept && item.last_byte |=> phase == PH_TAG0 && byte_count == '0 && seen_flags == 2'b00)
    else $error("parser not restarted after packet");

endmodule

`default_nettype wire

[tb/thp_result_checker.sv]
// ----------------------------------------------------------------------------
// thp_result_checker: scoreboard of the teredo header parser
// Follows every byte transfer on the item channel through a parse of its own,
// queues one predicted report per packet, and compares each result transfer
// field by field with the oldest queued report.
// ----------------------------------------------------------------------------
`default_nettype none

module thp_result_checker
  import thp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  input  wire logic    item_ready,
  input  wire item_t   item,
  input  wire logic    result_valid,
  input  wire logic    result_ready,
  input  wire result_t result,
  output int           outstanding,
  output int           mismatches
);

  // ipv6 byte count saturates here
  localparam logic [CNT_W-1:0] COUNT_CAP = {CNT_W{1'b1}} >> (CNT_W - LEN_WIDTH_DEF);

  phase_t           phase;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] plen;
  logic [OFF_W-1:0] hdr_start;
  logic [OFF_W-1:0] skip_left;
  logic [OFF_W-1:0] origin_at;
  logic [7:0]       tag_hi;
  logic [7:0]       id_len;
  logic             origin_done;
  logic             auth_done;
  logic [2:0]       err;
  result_t          pending_reports[$];
  int unsigned      reports_seen;

  task automatic clear_parser();
    phase       = PH_TAG0;
    count       = '0;
    plen        = '0;
    hdr_start   = '0;
    skip_left   = '0;
    origin_at   = '0;
    tag_hi      = '0;
    id_len      = '0;
    origin_done = 1'b0;
    auth_done   = 1'b0;
    err         = ST_OK;
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("report %0d %s: got %0d, wanted %0d", reports_seen, what, got, want);
    mismatches++;
  endtask

  task automatic parse_byte(input item_t it);
    logic [15:0] tag;
    result_t     r;
    tag = {tag_hi, it.data_byte};
    case (phase)
      PH_TAG0: begin
        hdr_start = count[OFF_W-1:0];
        tag_hi    = it.data_byte;
        count     = count + 1'b1;
        phase     = PH_TAG1;
      end
      PH_TAG1: begin
        count = count + 1'b1;
        if (tag == {8'h00, TAG_ORIGIN}) begin
          if (origin_done) begin
            err   = ST_MISORDERED;
            phase = PH_ERR;
          end else begin
            skip_left = ORIGIN_SKIP;
            err       = ST_TRUNC_ORIGIN;
            phase     = PH_SKIP;
          end
        end else if (tag == {8'h00, TAG_AUTH}) begin
          if (origin_done || auth_done) begin
            err   = ST_MISORDERED;
            phase = PH_ERR;
          end else begin
            err   = ST_TRUNC_AUTH;
            phase = PH_AUTH_ID;
          end
        end else if (tag[15:12] == TAG_IPV6_NIB) begin
          count = IPV6_START;
          plen  = '0;
          phase = PH_IPV6;
        end else begin
          err   = ST_UNKNOWN_TAG;
          phase = PH_ERR;
        end
      end
      PH_AUTH_ID: begin
        id_len = it.data_byte;
        count  = count + 1'b1;
        phase  = PH_AUTH_AU;
      end
      PH_AUTH_AU: begin
        // four bytes of the auth header are already behind us
        skip_left = AUTH_SKIP + id_len + it.data_byte;
        count     = count + 1'b1;
        phase     = PH_SKIP;
      end
      PH_SKIP: begin
        count = count + 1'b1;
        if (skip_left != 0) skip_left = skip_left - 1'b1;
        if (skip_left == 0) begin
          if (err == ST_TRUNC_ORIGIN) begin
            origin_done = 1'b1;
            origin_at   = hdr_start;
          end else begin
            auth_done = 1'b1;
          end
          phase = PH_TAG0;
        end
      end
      PH_IPV6: begin
        if (count == PLEN_HI_POS) plen[CNT_W-1:8] = it.data_byte;
        else if (count == PLEN_LO_POS) plen[7:0] = it.data_byte;
        if (count < COUNT_CAP) count = count + 1'b1;
      end
      default: ;
    endcase

    if (it.last_byte) begin
      r = '0;
      case (phase)
        PH_TAG0, PH_TAG1: r.status = ST_TRUNC_TAG;
        PH_IPV6: begin
          if (count < IPV6_MIN) begin
            r.status = ST_SHORT_IPV6;
          end else if (count >= COUNT_CAP || count - IPV6_MIN != plen) begin
            r.status = ST_LEN_MISMATCH;
          end else begin
            r.status      = ST_OK;
            r.packet_ok   = 1'b1;
            r.ipv6_offset = hdr_start;
          end
        end
        default: r.status = err;
      endcase
      r.origin_seen   = origin_done;
      r.origin_offset = origin_done ? origin_at : '0;
      r.auth_seen     = auth_done;
      pending_reports.push_back(r);
      clear_parser();
    end
  endtask

  task automatic check_report(input result_t got);
    result_t want;
    if (pending_reports.size() == 0) begin
      report_mismatch("result with no packet pending", 1, 0);
    end else begin
      want = pending_reports.pop_front();
      if (got.packet_ok !== want.packet_ok)
        report_mismatch("packet_ok", got.packet_ok, want.packet_ok);
      if (got.status !== want.status)
        report_mismatch("status", got.status, want.status);
      if (got.ipv6_offset !== want.ipv6_offset)
        report_mismatch("ipv6_offset", got.ipv6_offset, want.ipv6_offset);
      if (got.origin_seen !== want.origin_seen)
        report_mismatch("origin_seen", got.origin_seen, want.origin_seen);
      if (got.origin_offset !== want.origin_offset)
        report_mismatch("origin_offset", got.origin_offset, want.origin_offset);
      if (got.auth_seen !== want.auth_seen)
        report_mismatch("auth_seen", got.auth_seen, want.auth_seen);
    end
    reports_seen++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_parser();
      pending_reports.delete();
      reports_seen = 0;
      mismatches   = 0;
    end else begin
      if (item_valid && item_ready) parse_byte(item);
      if (result_valid && result_ready) check_report(result);
    end
    outstanding <= pending_reports.size();
  end

endmodule

`default_nettype wire

[tb/tb_teredo_header_parser.sv]
// ----------------------------------------------------------------------------
// tb_teredo_header_parser: testbench of the teredo header parser
// Sends directed packets for each header rule and error code, then random
// packets built mostly from well-formed header chains, with random gaps on
// both channels, a long result stall and a full drain in the middle.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_teredo_header_parser;
  import thp_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 150;

  logic        clk;
  logic        rst          = 1'b1;
  logic        item_valid   = 1'b0;
  logic        item_ready;
  item_t       item         = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  result_t     result;
  int          outstanding;
  int          mismatches;
  logic [7:0]  pkt[$];
  int unsigned bytes_sent   = 0;
  int unsigned packets_sent = 0;
  int unsigned gap_pct      = 0;
  int unsigned stall_cycles = 0;
  bit          calm         = 1'b0;
  bit          hold_req     = 1'b0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  teredo_header_parser i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  thp_result_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .outstanding  (outstanding),
    .mismatches   (mismatches)
  );

  // result side: random stalls, one long hold on request
  initial begin
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        result_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((item_valid && item_ready) || (result_valid && result_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("teredo_header_parser: mismatch");
      $finish;
    end
  end

  task automatic put_random(input int n);
    repeat (n) pkt.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic put_origin();
    pkt.push_back(8'h00);
    pkt.push_back(TAG_ORIGIN);
    put_random(6);
  endtask

  task automatic put_auth(input int id, input int au);
    pkt.push_back(8'h00);
    pkt.push_back(TAG_AUTH);
    pkt.push_back(8'(id));
    pkt.push_back(8'(au));
    put_random(9 + id + au);
  endtask

  // inner ipv6 header with a given payload length field, cut at total bytes
  task automatic put_ipv6(input int plen, input int total);
    for (int i = 0; i < total; i++) begin
      case (i)
        0:       pkt.push_back({TAG_IPV6_NIB, 4'($urandom_range(0, 15))});
        4:       pkt.push_back(plen[15:8]);
        5:       pkt.push_back(plen[7:0]);
        default: pkt.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  task automatic cut_to(input int n);
    while (pkt.size() > n) void'(pkt.pop_back());
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt.size(); i++) begin
      if (!calm && $urandom_range(1, 100) <= gap_pct) begin
        item_valid <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      item_valid     <= 1'b1;
      item.data_byte <= pkt[i];
      item.last_byte <= (i == pkt.size() - 1);
      @(posedge clk);
      while (!item_ready) @(posedge clk);
      bytes_sent++;
    end
    pkt.delete();
    packets_sent++;
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic random_packet();
    int id;
    int au;
    int plen;
    int total;
    if ($urandom_range(0, 99) < 8) begin
      put_random($urandom_range(1, 12));
    end else begin
      if ($urandom_range(0, 9) == 0) begin
        id = $urandom_range(0, 255);
        au = $urandom_range(0, 255);
      end else begin
        id = $urandom_range(0, 6);
        au = $urandom_range(0, 6);
      end
      case ($urandom_range(0, 9))
        3, 4: put_auth(id, au);
        5, 6: put_origin();
        7, 8: begin
          put_auth(id, au);
          put_origin();
        end
        9: begin
          case ($urandom_range(0, 3))
            0: begin
              put_origin();
              put_auth(id, au);
            end
            1: begin
              put_origin();
              put_origin();
            end
            2: begin
              put_auth(id, au);
              put_auth(au, id);
            end
            default: begin
              put_auth(id, au);
              put_origin();
              put_origin();
            end
          endcase
        end
        default: ;
      endcase
      plen  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 400) : $urandom_range(0, 24);
      total = 40 + plen;
      case ($urandom_range(0, 9))
        6: put_ipv6($urandom_range(0, 1) ? plen + $urandom_range(1, 3)
                                         : $urandom_range(0, 65535), total);
        7: put_random($urandom_range(2, 6));
        8: ;
        9: put_ipv6(plen, $urandom_range(1, total - 1));
        default: put_ipv6(plen, total);
      endcase
      if (pkt.size() == 0) put_random(1);
      if ($urandom_range(0, 6) == 0) cut_to($urandom_range(1, pkt.size()));
    end
    send_packet();
  endtask

  initial begin
    logic [15:0] odd_tags[5];
    odd_tags = '{16'h0002, 16'h0100, 16'hffff, 16'h5fff, 16'h7000};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // truncation at every header stage
    gap_pct = 20;
    pkt.push_back(8'h60);
    send_packet();
    pkt.push_back(8'h00);
    pkt.push_back(TAG_ORIGIN);
    send_packet();
    put_origin();
    send_packet();
    put_origin();
    put_random(1);
    send_packet();
    put_auth(5, 3);
    cut_to(3);
    send_packet();
    put_auth(2, 1);
    cut_to(10);
    send_packet();
    put_auth(4, 4);
    put_origin();
    cut_to(26);
    send_packet();

    // good chains, largest auth header
    put_auth(255, 255);
    put_ipv6(0, 40);
    send_packet();
    put_auth(0, 0);
    put_origin();
    put_ipv6(8, 48);
    send_packet();

    // misordered and repeated headers
    put_origin();
    put_auth(1, 1);
    send_packet();
    put_origin();
    put_origin();
    put_ipv6(0, 40);
    send_packet();
    put_auth(3, 0);
    put_auth(0, 3);
    send_packet();
    put_auth(0, 0);
    put_origin();
    put_origin();
    send_packet();

    // unknown tags, trailing bytes ignored
    foreach (odd_tags[k]) begin
      pkt.push_back(odd_tags[k][15:8]);
      pkt.push_back(odd_tags[k][7:0]);
      pkt.push_back(8'h00);
      pkt.push_back(8'h00);
      send_packet();
    end

    // inner ipv6 length rules
    put_ipv6(0, 40);
    send_packet();
    put_ipv6(0, 39);
    send_packet();
    put_ipv6(0, 2);
    send_packet();
    put_ipv6(5, 44);
    send_packet();
    put_ipv6(16'hffff, 41);
    send_packet();

    bytes_sent   = 0;
    packets_sent = 0;
    while (bytes_sent < 1000 || packets_sent < 16 || !calm) begin
      case ($urandom_range(0, 3))
        0, 1:    gap_pct = 0;
        2:       gap_pct = 10;
        default: gap_pct = 25;
      endcase
      if (packets_sent == 4) begin
        // fill the parser while results are held back
        item_valid <= 1'b0;
        hold_req = 1'b1;
        @(posedge clk);
        while (hold_req) @(posedge clk);
        gap_pct = 0;
        repeat (8) begin
          pkt.push_back(8'hff);
          put_random(1);
          send_packet();
        end
      end
      if (packets_sent == 14) wait_drained();
      if (bytes_sent >= 850) calm = 1'b1;
      random_packet();
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) $display("teredo_header_parser: match");
    else $display("teredo_header_parser: mismatch");
    $finish;
  end

endmodule

`default_nettype wire

[teredo_header_parser.f]
design/thp_pkg.sv
design/teredo_header_parser.sv
tb/thp_result_checker.sv
tb/tb_teredo_header_parser.sv
